// ----- hdl/fgf_pkg.sv -----
// Shared types and constants for the free-gap fit query block.
// Used by fgf_ctrl, fgf_datapath, free_gap_fit_query, fgf_fit_checker and the testbench; no dependencies.
package fgf_pkg;

   // Obstacle map depth and derived widths
   localparam int POSITIONS = 4096;
   localparam int ADDR_W    = $clog2(POSITIONS);
   localparam int CNT_W     = ADDR_W + 1;            // scan counter reaches POSITIONS
   localparam int POS_W     = 12;                    // position / block_size field width
   localparam int LIM_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int DIST_W    = (POS_W > ADDR_W) ? POS_W : ADDR_W;

   // Stream word widths
   localparam int REQ_DATA_W = 24;                   // position, block_size
   localparam int RSP_DATA_W = 8;                    // fits, zero fill

   // Command codes carried in req_tuser
   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_RESULT
   } fgf_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic clear_wr;     // write zero at counter, advance counter
      logic place_wr;     // set map bit at request position
      logic load_query;   // latch query operands, restart scan
      logic scan_issue;   // read map at counter, advance counter
      logic tail;         // fold final stretch into best gap
      logic res_load;     // load result into output register
   } fgf_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_done;   // counter at last map entry during clear
      logic issue_done;   // all reads of the scan issued
      logic pipe_busy;    // a read is still in flight
      logic out_busy;     // output register full and stalled
   } fgf_stat_type;

endpackage

// ----- hdl/free_gap_fit_query.sv -----
// Top level of the free-gap fit query block: stream ports, controller and datapath.
// Depends on fgf_pkg, fgf_ctrl, fgf_datapath (and fgf_ram below it).
//
// Usage:
//   The req channel takes one word per command. req_tuser selects the kind:
//   place sets an obstacle at position, query asks whether a free stretch of
//   at least block_size lies in [0, position]. Only queries give a rsp word,
//   with fits in bit 0.
//   A place leaves the block idle; the next word is taken in the following cycle.
//   A query scans the obstacle map one entry per cycle through the single
//   RAM read port, so it occupies the block from accept until its result
//   is loaded into the output register.
//   After reset the block runs a clearing pass over all 4096 map entries,
//   one entry per cycle, with req_tready low.
//   The result sits in an output register; while the receiver stalls, new
//   place words are still taken, and a following query scans but holds its
//   result until the register frees up.
module free_gap_fit_query (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fgf_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] position, [23:12] block_size
   input  logic                           req_tuser,  // [0] cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fgf_pkg::RSP_DATA_W-1:0] rsp_tdata   // [0] fits, [7:1] zero
);
   import fgf_pkg::*;

   fgf_cmd_type  ctl;
   fgf_stat_type sts;
   logic         fits;

   fgf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   fgf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_position   (req_tdata[POS_W-1:0]),
      .req_block_size (req_tdata[2*POS_W-1:POS_W]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_fits       (fits)
   );

   assign rsp_tdata = {{(RSP_DATA_W-1){1'b0}}, fits};

   // A query holds off further words while it scans
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_QUERY) |=> !req_tready)
      else $error("req_tready high right after query accept");

   // A place never produces a response word
   a_place_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_PLACE && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response word after place");

   // Map write port is never claimed twice
   a_wr_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctl.place_wr |-> !ctl.clear_wr)
      else $error("place during clearing pass");

   // Response only appears from a result load
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl.res_load))
      else $error("rsp_tvalid rose without result load");

endmodule

// ----- hdl/fgf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fgf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fgf_ctrl.sv -----
// Sequencer for the free-gap fit query block: clear pass, idle, scan, tail, result.
// Depends on fgf_pkg.
module fgf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_kind,
   output logic                 req_tready,
   input  fgf_pkg::fgf_stat_type sts,
   output fgf_pkg::fgf_cmd_type  ctl
);
   import fgf_pkg::*;

   fgf_state_type state_ff;
   fgf_state_type state_in;
   logic          accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_kind == CMD_QUERY) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.issue_done && !sts.pipe_busy) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            ctl.place_wr   = accept && (req_kind == CMD_PLACE);
            ctl.load_query = accept && (req_kind == CMD_QUERY);
         end
         ST_SCAN: begin
            ctl.scan_issue = !sts.issue_done;
         end
         ST_TAIL: begin
            ctl.tail = 1'b1;
         end
         ST_RESULT: begin
            ctl.res_load = !sts.out_busy;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/fgf_datapath.sv -----
// Datapath: obstacle map RAM, scan counter, last-obstacle and best-gap
// registers, and the output register. Depends on fgf_pkg and fgf_ram.
module fgf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  fgf_pkg::fgf_cmd_type        ctl,
   output fgf_pkg::fgf_stat_type       sts,
   input  logic [fgf_pkg::POS_W-1:0]   req_position,
   input  logic [fgf_pkg::POS_W-1:0]   req_block_size,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_fits
);
   import fgf_pkg::*;

   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [POS_W-1:0]  x_ff,     x_in;
   logic [POS_W-1:0]  size_ff,  size_in;
   logic [ADDR_W-1:0] last_ff,  last_in;
   logic [DIST_W-1:0] best_ff,  best_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_fits_ff,  rsp_fits_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_data;
   logic              rd_data;
   logic [LIM_W-1:0]  pos_ext;
   logic              pos_in_map;
   logic [DIST_W-1:0] gap;
   logic [DIST_W-1:0] tail_gap;

   // Map write port: zero fill during clear, set bit on place
   assign pos_ext    = LIM_W'(req_position);
   assign pos_in_map = (pos_ext < LIM_W'(POSITIONS));
   assign wr_en      = ctl.clear_wr | (ctl.place_wr & pos_in_map);
   assign wr_addr    = ctl.clear_wr ? cnt_ff[ADDR_W-1:0] : ADDR_W'(pos_ext);
   assign wr_data    = ~ctl.clear_wr;

   fgf_ram #(
      .WIDTH (1),
      .DEPTH (POSITIONS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Scan counter and operand capture
   always_comb begin
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      x_in     = x_ff;
      size_in  = size_ff;
      if (ctl.load_query) begin
         cnt_in   = '0;
         x_in     = req_position;
         size_in  = req_block_size;
         limit_in = pos_in_map ? CNT_W'(pos_ext) : CNT_W'(POSITIONS);
      end else if (ctl.clear_wr || ctl.scan_issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Read pipeline tag: data for rd_addr_ff arrives in the cycle after issue
   assign rd_vld_in  = ctl.scan_issue;
   assign rd_addr_in = cnt_ff[ADDR_W-1:0];

   // Gap tracking
   assign gap      = DIST_W'(rd_addr_ff) - DIST_W'(last_ff);
   assign tail_gap = DIST_W'(x_ff) - DIST_W'(last_ff);

   always_comb begin
      last_in = last_ff;
      best_in = best_ff;
      if (ctl.load_query) begin
         last_in = '0;
         best_in = '0;
      end else if (ctl.tail) begin
         if (tail_gap > best_ff) best_in = tail_gap;
      end else if (rd_vld_ff && rd_data) begin
         last_in = rd_addr_ff;
         if (gap > best_ff) best_in = gap;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fits_in  = rsp_fits_ff;
      if (ctl.res_load) begin
         rsp_valid_in = 1'b1;
         rsp_fits_in  = (best_ff >= DIST_W'(size_ff));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      x_ff        <= x_in;
      size_ff     <= size_in;
      last_ff     <= last_in;
      best_ff     <= best_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_fits_ff <= rsp_fits_in;
   end

   // Status
   assign sts.clear_done = (cnt_ff[ADDR_W-1:0] == ADDR_W'(POSITIONS - 1));
   assign sts.issue_done = (cnt_ff == limit_ff);
   assign sts.pipe_busy  = rd_vld_ff;
   assign sts.out_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fits  = rsp_fits_ff;

endmodule

// ----- sim/fgf_fit_checker.sv -----
// Checker for free_gap_fit_query: watches req and rsp words and predicts each fits bit.
// Counts mismatches and the fits words still due. Depends on fgf_pkg.
`timescale 1ns / 100ps

module fgf_fit_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [fgf_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] position, [23:12] block_size
   input  logic                           req_tuser,  // [0] cmd
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [fgf_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] fits, [7:1] zero
   output int                             mismatch_count,
   output int                             fits_pending
);
   import fgf_pkg::*;

   localparam int REPORT_MAX = 10;

   // Shadow of the obstacle map and the fits words owed by accepted queries
   logic [POSITIONS-1:0] obstacle_seen;
   logic                 fits_due[$];

   initial begin
      mismatch_count = 0;
      fits_pending   = 0;
      obstacle_seen  = '0;
   end

   // Widest free stretch in [0, right_end] compared with the block size
   function automatic logic gap_fits(input logic [POS_W-1:0] right_end,
                                     input logic [POS_W-1:0] need);
      int prev_obstacle;
      int widest;
      int stop;
      int x_end;
      prev_obstacle = 0;
      widest        = 0;
      x_end         = int'(right_end);
      stop          = (x_end < POSITIONS) ? x_end : POSITIONS;
      for (int p = 0; p < stop; p++) begin
         if (obstacle_seen[p]) begin
            if (p - prev_obstacle > widest) widest = p - prev_obstacle;
            prev_obstacle = p;
         end
      end
      // final stretch up to x; an obstacle at x itself is not below x
      if (x_end - prev_obstacle > widest) widest = x_end - prev_obstacle;
      return (widest >= int'(need));
   endfunction

   task automatic note_failure(input string what, input logic [RSP_DATA_W-1:0] want,
                               input logic [RSP_DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // Compare rsp words first, then fold in the req word of the same edge
   always @(posedge clock) begin
      if (reset) begin
         obstacle_seen = '0;
         fits_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fits_due.size() == 0) begin
               note_failure("rsp word with no query waiting", '0, rsp_tdata);
            end else begin
               logic [RSP_DATA_W-1:0] want;
               want = {{(RSP_DATA_W-1){1'b0}}, fits_due.pop_front()};
               if (rsp_tdata !== want) note_failure("fits mismatch", want, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_QUERY) begin
               // queue the predicted fits bit at the tail
               fits_due = {fits_due,
                           gap_fits(req_tdata[POS_W-1:0], req_tdata[2*POS_W-1:POS_W])};
            end else if (int'(req_tdata[POS_W-1:0]) < POSITIONS) begin
               // placing twice leaves the map as it is
               obstacle_seen[req_tdata[POS_W-1:0]] = 1'b1;
            end
         end
      end
      fits_pending = fits_due.size();
   end

endmodule

// ----- sim/tb_free_gap_fit_query.sv -----
// Testbench top for free_gap_fit_query: clock, reset, req/rsp stimulus and verdict.
// Depends on fgf_pkg, free_gap_fit_query and fgf_fit_checker.
`timescale 1ns / 100ps

module tb_free_gap_fit_query;
   import fgf_pkg::*;

   localparam int IDLE_PCT       = 14;
   localparam int RANDOM_ITEMS   = 118;
   localparam int RSP_HOLD_LEN   = 600;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 40000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [11:0] position, [23:12] block_size
   logic                  req_tuser;   // [0] cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [0] fits, [7:1] zero

   int   mismatch_count;
   int   fits_pending;
   int   stall_cycles = 0;
   int   hold_requests = 0;
   int   holds_served = 0;
   logic steady = 1'b0;                // no idling on either side while set

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   free_gap_fit_query DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fgf_fit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .fits_pending   (fits_pending)
   );

   // Receiver: random stalls, plus a long hold-off on request from the sender
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_LEN - 1) @(negedge clock);
         end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // One req word: optional idle gap, then hold valid until accepted
   task automatic send_word(input logic cmd, input logic [POS_W-1:0] pos,
                            input logic [POS_W-1:0] size);
      int gap;
      gap = 0;
      if (!steady)
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      @(negedge clock);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {size, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic             cmd;
      int               pos;
      int               size;
      int               size_top;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_PLACE;
      req_tdata  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty map, field extremes, zero end and zero size
      send_word(CMD_QUERY, 12'd1, 12'd1);
      send_word(CMD_QUERY, 12'hFFF, 12'hFFF);
      send_word(CMD_QUERY, 12'd100, 12'd101);
      send_word(CMD_QUERY, 12'd0, 12'd0);
      send_word(CMD_QUERY, 12'd0, 12'd1);
      send_word(CMD_QUERY, 12'd10, 12'd0);
      // obstacle at zero changes no answer
      send_word(CMD_PLACE, 12'd0, 12'd0);
      send_word(CMD_QUERY, 12'd5, 12'd5);
      // obstacle at the top end, placed twice, then queried at x
      send_word(CMD_PLACE, 12'hFFF, 12'hFFF);
      send_word(CMD_PLACE, 12'hFFF, 12'h000);
      send_word(CMD_QUERY, 12'hFFF, 12'hFFF);
      // obstacle exactly at x, then just below x
      send_word(CMD_PLACE, 12'd100, 12'd0);
      send_word(CMD_QUERY, 12'd100, 12'd100);
      send_word(CMD_QUERY, 12'd101, 12'd100);
      send_word(CMD_QUERY, 12'd101, 12'd101);
      // interior gap against the final stretch
      send_word(CMD_PLACE, 12'd2048, 12'd0);
      send_word(CMD_QUERY, 12'hFFF, 12'd2047);
      send_word(CMD_QUERY, 12'hFFF, 12'd2048);
      // tight cluster near the origin
      send_word(CMD_PLACE, 12'd1, 12'd0);
      send_word(CMD_PLACE, 12'd2, 12'd0);
      send_word(CMD_QUERY, 12'd3, 12'd2);
      send_word(CMD_QUERY, 12'd3, 12'd1);

      // Random: mostly short scans, a few over the whole map
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 70 && n < 110);
         if (n == 30) hold_requests++;
         cmd = ($urandom_range(0, 99) < 55) ? CMD_QUERY : CMD_PLACE;
         pos = ($urandom_range(0, 99) < 12) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 255);
         if ($urandom_range(0, 1)) begin
            size = $urandom_range(0, pos / 4 + 3);
         end else begin
            size_top = (pos + 2 > 4095) ? 4095 : pos + 2;
            size     = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, size_top);
         end
         send_word(cmd, pos[POS_W-1:0], size[POS_W-1:0]);
      end
      steady = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain: all fits words in, then a short quiet stretch
      while (fits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && fits_pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/fgf_pkg.sv
hdl/fgf_ram.sv
hdl/fgf_ctrl.sv
hdl/fgf_datapath.sv
hdl/free_gap_fit_query.sv
sim/fgf_fit_checker.sv
sim/tb_free_gap_fit_query.sv
